/* hdl/pms_pkg.sv */
// ----------------------------------------------------------------------------
// pms_pkg
// shared constants, types and command/status bundles of the pwm motif scanner
// ----------------------------------------------------------------------------
package pms_pkg;

    // matrix geometry
    localparam int MAX_MOTIF_LEN = 32;
    localparam int WEIGHT_BITS   = 16;
    localparam int ROW_W         = $clog2(MAX_MOTIF_LEN);
    localparam int LEN_W         = $clog2(MAX_MOTIF_LEN + 1);
    localparam int MAX_SLOT      = 4;  // row word slot that holds the row maximum

    // field widths
    localparam int MOTIF_LEN_W = 6;
    localparam int SCORE_W     = 22;
    localparam int STRAND_W    = 2;
    localparam int POS_W       = 31;
    localparam int WROW_W      = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int ACC_W       = WEIGHT_BITS + 2 + $clog2(MAX_MOTIF_LEN);

    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MOTIF_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SCORE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRAND_MODE  = 2'd2;

    // strand codes
    localparam logic [STRAND_W-1:0] MODE_FORWARD = 2'd0;
    localparam logic [STRAND_W-1:0] MODE_REVERSE = 2'd1;
    localparam logic [STRAND_W-1:0] MODE_BOTH    = 2'd2;
    localparam logic STRAND_FWD = 1'b0;
    localparam logic STRAND_REV = 1'b1;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_BASE = 1'b1;

    // ascii bases and window codes
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_C_UP = 8'h43;
    localparam logic [7:0] CH_G_UP = 8'h47;
    localparam logic [7:0] CH_T_UP = 8'h54;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_C_LO = 8'h63;
    localparam logic [7:0] CH_G_LO = 8'h67;
    localparam logic [7:0] CH_T_LO = 8'h74;
    localparam logic [2:0] BASE_A    = 3'd0;
    localparam logic [2:0] BASE_C    = 3'd1;
    localparam logic [2:0] BASE_G    = 3'd2;
    localparam logic [2:0] BASE_T    = 3'd3;
    localparam logic [2:0] BASE_NONE = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_RD,
        S_LOAD_WR,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_SCORE,
        S_PICK,
        S_EMIT_F,
        S_EMIT_R
    } t_state;

    typedef struct packed {
        logic take_base;
        logic take_load;
        logic ld_read;
        logic ld_write;
        logic step;
        logic score;
        logic emit_f;
        logic emit_r;
    } t_cmd;

    typedef struct packed {
        logic fill_ok;
        logic last_step;
        logic hit_f;
        logic hit_r;
    } t_stat;

endpackage

/* hdl/pms_ctrl.sv */
// ----------------------------------------------------------------------------
// pms_ctrl
// sequencer of the scanner: weight loads, window scan, result emission
// ----------------------------------------------------------------------------
module pms_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_kind,
    output logic           o_in_stall,
    input  logic           i_out_stall,
    input  pms_pkg::t_stat i_stat,
    output pms_pkg::t_cmd  o_cmd
);

    pms_pkg::t_state r_state;
    pms_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pms_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pms_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_kind == pms_pkg::KIND_BASE) ? pms_pkg::S_CHECK
                                                             : pms_pkg::S_LOAD_RD;
                end
            end
            pms_pkg::S_LOAD_RD: n_state = pms_pkg::S_LOAD_WR;
            pms_pkg::S_LOAD_WR: n_state = pms_pkg::S_IDLE;
            pms_pkg::S_CHECK: begin
                n_state = i_stat.fill_ok ? pms_pkg::S_SCAN : pms_pkg::S_IDLE;
            end
            pms_pkg::S_SCAN: begin
                if (i_stat.last_step) begin
                    n_state = pms_pkg::S_DRAIN;
                end
            end
            pms_pkg::S_DRAIN: n_state = pms_pkg::S_SCORE;
            pms_pkg::S_SCORE: n_state = pms_pkg::S_PICK;
            pms_pkg::S_PICK: begin
                if (i_stat.hit_f) begin
                    n_state = pms_pkg::S_EMIT_F;
                end else if (i_stat.hit_r) begin
                    n_state = pms_pkg::S_EMIT_R;
                end else begin
                    n_state = pms_pkg::S_IDLE;
                end
            end
            pms_pkg::S_EMIT_F: begin
                if (!i_out_stall) begin
                    n_state = i_stat.hit_r ? pms_pkg::S_EMIT_R : pms_pkg::S_IDLE;
                end
            end
            pms_pkg::S_EMIT_R: begin
                if (!i_out_stall) begin
                    n_state = pms_pkg::S_IDLE;
                end
            end
            default: n_state = pms_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            pms_pkg::S_IDLE: begin
                o_in_stall      = 1'b0;
                o_cmd.take_base = i_in_valid && (i_kind == pms_pkg::KIND_BASE);
                o_cmd.take_load = i_in_valid && (i_kind == pms_pkg::KIND_LOAD);
            end
            pms_pkg::S_LOAD_RD: o_cmd.ld_read  = 1'b1;
            pms_pkg::S_LOAD_WR: o_cmd.ld_write = 1'b1;
            pms_pkg::S_SCAN:    o_cmd.step     = 1'b1;
            pms_pkg::S_SCORE:   o_cmd.score    = 1'b1;
            pms_pkg::S_EMIT_F:  o_cmd.emit_f   = 1'b1;
            pms_pkg::S_EMIT_R:  o_cmd.emit_r   = 1'b1;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* hdl/pms_datapath.sv */
// ----------------------------------------------------------------------------
// pms_datapath
// matrix row memory, base window, score accumulators and result registers
// ----------------------------------------------------------------------------
module pms_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pms_pkg::t_cmd                          i_cmd,
    output pms_pkg::t_stat                         o_stat,
    // input item fields
    input  logic                                   i_new_region,
    input  logic [7:0]                             i_base_char,
    input  logic [pms_pkg::POS_W-1:0]              i_position,
    input  logic [pms_pkg::WROW_W-1:0]             i_weight_row,
    input  logic [1:0]                             i_weight_column,
    input  logic signed [pms_pkg::WEIGHT_BITS-1:0] i_weight_value,
    // configuration writes
    input  logic                                   i_cfg_write,
    input  logic [pms_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [pms_pkg::SCORE_W-1:0]            i_cfg_data,
    // result fields
    output logic signed [pms_pkg::SCORE_W-1:0]     o_score,
    output logic [pms_pkg::POS_W-1:0]              o_start_position,
    output logic                                   o_strand,
    output logic                                   o_last_hit
);

    localparam int MAX   = pms_pkg::MAX_MOTIF_LEN;
    localparam int ROW_W = pms_pkg::ROW_W;
    localparam int LEN_W = pms_pkg::LEN_W;
    localparam int WB    = pms_pkg::WEIGHT_BITS;
    localparam int ACC_W = pms_pkg::ACC_W;
    localparam int SW    = pms_pkg::SCORE_W;

    typedef logic [pms_pkg::MAX_SLOT:0][WB-1:0] t_row;

    function automatic logic [2:0] base_code(input logic [7:0] c);
        logic [2:0] code;
        case (c) inside
            pms_pkg::CH_A_UP, pms_pkg::CH_A_LO: code = pms_pkg::BASE_A;
            pms_pkg::CH_C_UP, pms_pkg::CH_C_LO: code = pms_pkg::BASE_C;
            pms_pkg::CH_G_UP, pms_pkg::CH_G_LO: code = pms_pkg::BASE_G;
            pms_pkg::CH_T_UP, pms_pkg::CH_T_LO: code = pms_pkg::BASE_T;
            default:                            code = pms_pkg::BASE_NONE;
        endcase
        return code;
    endfunction

    // configuration registers
    logic [pms_pkg::MOTIF_LEN_W-1:0] r_motif_length;
    logic signed [SW-1:0]            r_min_score;
    logic [pms_pkg::STRAND_W-1:0]    r_strand_mode;
    logic [LEN_W-1:0]                len_eff;
    logic [ROW_W-1:0]                len_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motif_length <= pms_pkg::MOTIF_LEN_W'(1);
            r_min_score    <= pms_pkg::SCORE_MIN;
            r_strand_mode  <= pms_pkg::MODE_BOTH;
        end else if (i_cfg_write) begin
            case (i_cfg_index)
                pms_pkg::REG_MOTIF_LENGTH:
                    r_motif_length <= i_cfg_data[pms_pkg::MOTIF_LEN_W-1:0];
                pms_pkg::REG_MIN_SCORE:
                    r_min_score <= signed'(i_cfg_data);
                pms_pkg::REG_STRAND_MODE:
                    r_strand_mode <= i_cfg_data[pms_pkg::STRAND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // zero acts as one, oversize clamps to the matrix depth
    always_comb begin
        if (r_motif_length == '0) begin
            len_eff = LEN_W'(1);
        end else if (32'(r_motif_length) > MAX) begin
            len_eff = LEN_W'(MAX);
        end else begin
            len_eff = LEN_W'(r_motif_length);
        end
        len_m1 = ROW_W'(len_eff - LEN_W'(1));
    end

    // load item capture
    logic [pms_pkg::WROW_W-1:0] r_ld_row;
    logic [1:0]                 r_ld_col;
    logic [WB-1:0]              r_ld_val;
    logic                       ld_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_load) begin
            r_ld_row <= i_weight_row;
            r_ld_col <= i_weight_column;
            r_ld_val <= i_weight_value;
        end
    end

    assign ld_ok = (32'(r_ld_row) < MAX);

    // base window, newest base in the top slot
    logic [2:0]           r_win [MAX];
    logic [LEN_W-1:0]     r_fill;
    logic [pms_pkg::POS_W-1:0] r_pos;
    logic [2:0]           new_code;

    assign new_code = base_code(i_base_char);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX; k++) begin
                r_win[k] <= pms_pkg::BASE_NONE;
            end
            r_fill <= '0;
        end else if (i_cmd.take_base) begin
            for (int k = 0; k < MAX - 1; k++) begin
                r_win[k] <= i_new_region ? pms_pkg::BASE_NONE : r_win[k+1];
            end
            r_win[MAX-1] <= new_code;
            if (i_new_region) begin
                r_fill <= LEN_W'(1);
            end else if (32'(r_fill) < MAX) begin
                r_fill <= r_fill + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_base) begin
            r_pos <= i_position;
        end
    end

    // scan index and row addresses
    logic [ROW_W-1:0] r_idx;
    logic [ROW_W-1:0] rev_row;
    logic [ROW_W-1:0] addr_a;
    logic [LEN_W:0]   win_sum;
    logic [ROW_W-1:0] win_idx;

    assign rev_row = len_m1 - r_idx;
    assign addr_a  = i_cmd.ld_read ? ROW_W'(r_ld_row) : r_idx;
    assign win_sum = (LEN_W+1)'(r_idx) + (LEN_W+1)'(MAX) - (LEN_W+1)'(len_eff);
    assign win_idx = win_sum[ROW_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_base) begin
            r_idx <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + ROW_W'(1);
        end
    end

    // row memory: four weights and the row maximum per word
    t_row r_mem [MAX];
    t_row r_rd_a;
    t_row r_rd_b;
    t_row wr_word;

    always_comb begin
        logic signed [WB-1:0] mx;
        wr_word           = r_rd_a;
        wr_word[r_ld_col] = r_ld_val;
        mx                = signed'(wr_word[0]);
        for (int c = 1; c < 4; c++) begin
            if (signed'(wr_word[c]) > mx) begin
                mx = signed'(wr_word[c]);
            end
        end
        wr_word[pms_pkg::MAX_SLOT] = mx;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_write && ld_ok) begin
            r_mem[ROW_W'(r_ld_row)] <= wr_word;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[rev_row];
    end

    // accumulate stage, one row of both strands per cycle
    logic                    r_pv;
    logic [2:0]              r_base_q;
    logic signed [ACC_W-1:0] r_acc_f;
    logic signed [ACC_W-1:0] r_acc_r;
    logic                    r_bad;
    logic [1:0]              bf;
    logic signed [ACC_W-1:0] d_f;
    logic signed [ACC_W-1:0] d_r;

    // the reverse term takes its maximum from the mirrored row
    always_comb begin
        bf  = r_base_q[1:0];
        d_f = ACC_W'(signed'(r_rd_a[bf]))
            - ACC_W'(signed'(r_rd_a[pms_pkg::MAX_SLOT]));
        d_r = ACC_W'(signed'(r_rd_b[2'd3 - bf]))
            - ACC_W'(signed'(r_rd_b[pms_pkg::MAX_SLOT]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_base_q <= r_win[win_idx];
        end
        if (i_cmd.take_base) begin
            r_acc_f <= '0;
            r_acc_r <= '0;
            r_bad   <= 1'b0;
        end else if (r_pv) begin
            r_acc_f <= r_acc_f + d_f;
            r_acc_r <= r_acc_r + d_r;
            if (r_base_q > pms_pkg::BASE_T) begin
                r_bad <= 1'b1;
            end
        end
    end

    // final scores, threshold and start coordinate
    logic signed [SW-1:0]      sc_f;
    logic signed [SW-1:0]      sc_r;
    logic signed [SW-1:0]      r_sc_f;
    logic signed [SW-1:0]      r_sc_r;
    logic                      r_hit_f;
    logic                      r_hit_r;
    logic [pms_pkg::POS_W-1:0] r_start;

    always_comb begin
        sc_f = (r_acc_f < ACC_W'(pms_pkg::SCORE_MIN)) ? pms_pkg::SCORE_MIN
                                                       : r_acc_f[SW-1:0];
        sc_r = (r_acc_r < ACC_W'(pms_pkg::SCORE_MIN)) ? pms_pkg::SCORE_MIN
                                                       : r_acc_r[SW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_f <= 1'b0;
            r_hit_r <= 1'b0;
        end else if (i_cmd.score) begin
            r_hit_f <= (r_strand_mode != pms_pkg::MODE_REVERSE) && !r_bad
                       && (sc_f >= r_min_score);
            r_hit_r <= (r_strand_mode != pms_pkg::MODE_FORWARD) && !r_bad
                       && (sc_r >= r_min_score);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.score) begin
            r_sc_f  <= sc_f;
            r_sc_r  <= sc_r;
            r_start <= r_pos - pms_pkg::POS_W'(len_m1);
        end
    end

    assign o_score          = i_cmd.emit_r ? r_sc_r : r_sc_f;
    assign o_start_position = r_start;
    assign o_strand         = i_cmd.emit_r ? pms_pkg::STRAND_REV
                                           : pms_pkg::STRAND_FWD;
    assign o_last_hit       = i_cmd.emit_r || !r_hit_r;

    assign o_stat.fill_ok   = (r_fill >= len_eff);
    assign o_stat.last_step = (r_idx == len_m1);
    assign o_stat.hit_f     = r_hit_f;
    assign o_stat.hit_r     = r_hit_r;

endmodule

/* hdl/pwm_motif_scanner_core.sv */
// ----------------------------------------------------------------------------
// pwm_motif_scanner_core
// dna base stream scanner scoring each window against a position weight matrix
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_stall): one item per handshake, either a
//   weight load (i_kind 0) or a sequence base (i_kind 1)
//   output channel (o_out_valid / i_out_stall): zero, one or two hit items per
//   base, forward strand first, o_last_hit marks the final one
//   config channel (i_cfg_valid / o_cfg_ready): ready is always high, write
//   only while no item is in flight
// sequence
//   load item: accept, row read, row write-back with new maximum
//   base item while the window is not yet full: accept, fill check
//   base item with a full window: accept, fill check, scan, drain, score,
//   pick and hit items; the scan walks one matrix row per cycle through
//   the row memory (two read ports: forward row and mirrored reverse row)
//   only one item is in work at a time, o_in_stall stays high until done
// reset
//   window emptied, fill count zero, registers to motif_length 1, min_score
//   most negative, both strands; matrix contents undefined until loaded
// stall
//   a stalled hit item holds its payload until taken, nothing is dropped
// ----------------------------------------------------------------------------
module pwm_motif_scanner_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input item channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_kind,
    input  logic                                   i_new_region,
    input  logic [7:0]                             i_base_char,
    input  logic [pms_pkg::POS_W-1:0]              i_position,
    input  logic [pms_pkg::WROW_W-1:0]             i_weight_row,
    input  logic [1:0]                             i_weight_column,
    input  logic signed [pms_pkg::WEIGHT_BITS-1:0] i_weight_value,
    // hit item channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [pms_pkg::SCORE_W-1:0]     o_score,
    output logic [pms_pkg::POS_W-1:0]              o_start_position,
    output logic                                   o_strand,
    output logic                                   o_last_hit,
    // configuration write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pms_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [pms_pkg::SCORE_W-1:0]            i_cfg_data
);

    pms_pkg::t_cmd  cmd;
    pms_pkg::t_stat stat;

    // registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    // sequencer: accept, load weights, scan rows, pick hits, hand them out
    pms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // storage and arithmetic
    pms_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_new_region     (i_new_region),
        .i_base_char      (i_base_char),
        .i_position       (i_position),
        .i_weight_row     (i_weight_row),
        .i_weight_column  (i_weight_column),
        .i_weight_value   (i_weight_value),
        .i_cfg_write      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_score          (o_score),
        .o_start_position (o_start_position),
        .o_strand         (o_strand),
        .o_last_hit       (o_last_hit)
    );

    // a hit is only shown while the block is busy with its base
    assign o_out_valid = cmd.emit_f || cmd.emit_r;

    // hits are never shown while a new item could be taken
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("hit item shown while input is open");

    // the reverse strand hit is always the last of its base
    a_rev_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_strand == pms_pkg::STRAND_REV)) |-> o_last_hit)
        else $error("reverse hit not marked last");

    // scores are relative to the best match and never positive
    a_score_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_score[pms_pkg::SCORE_W-1] || (o_score == '0)))
        else $error("positive score");

    // after the last hit is taken the output goes quiet
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_hit) |=> !o_out_valid)
        else $error("hit item after last hit");

endmodule

/* tb/sv/pms_hit_checker.sv */
// ----------------------------------------------------------------------------
// pms_hit_checker
// watches the item, hit and register channels of the pwm motif scanner,
// predicts the hit items of every accepted base and compares them in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pms_hit_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // item channel
    input  logic                                   i_in_valid,
    input  logic                                   i_in_stall,
    input  logic                                   i_kind,
    input  logic                                   i_new_region,
    input  logic [7:0]                             i_base_char,
    input  logic [pms_pkg::POS_W-1:0]              i_position,
    input  logic [pms_pkg::WROW_W-1:0]             i_weight_row,
    input  logic [1:0]                             i_weight_column,
    input  logic signed [pms_pkg::WEIGHT_BITS-1:0] i_weight_value,
    // hit channel
    input  logic                                   i_out_valid,
    input  logic                                   i_out_stall,
    input  logic signed [pms_pkg::SCORE_W-1:0]     i_score,
    input  logic [pms_pkg::POS_W-1:0]              i_start_position,
    input  logic                                   i_strand,
    input  logic                                   i_last_hit,
    // register channel
    input  logic                                   i_cfg_valid,
    input  logic                                   i_cfg_ready,
    input  logic [pms_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [pms_pkg::SCORE_W-1:0]            i_cfg_data,
    // status to the top
    output int                                     o_fail_count,
    output int                                     o_pending
);
    import pms_pkg::*;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [POS_W-1:0]          start_pos;
        logic                      strand;
        logic                      last_hit;
    } t_hit;

    // shadow of the matrix, the window and the registers
    logic signed [WEIGHT_BITS-1:0] weight_mem [4*MAX_MOTIF_LEN];
    logic signed [WEIGHT_BITS-1:0] row_peak [MAX_MOTIF_LEN];
    logic [2:0]                    window [MAX_MOTIF_LEN];
    int                            fill;
    logic [MOTIF_LEN_W-1:0]        cfg_len;
    logic signed [SCORE_W-1:0]     cfg_min;
    logic [STRAND_W-1:0]           cfg_mode;

    t_hit expected_hits[$];
    int   hit_errors = 0;

    function automatic logic [2:0] code_of(input logic [7:0] ch);
        case (ch)
            CH_A_UP, CH_A_LO: return BASE_A;
            CH_C_UP, CH_C_LO: return BASE_C;
            CH_G_UP, CH_G_LO: return BASE_G;
            CH_T_UP, CH_T_LO: return BASE_T;
            default: return BASE_NONE;
        endcase
    endfunction

    task automatic load_weight(input logic [WROW_W-1:0] row, input logic [1:0] col,
                               input logic signed [WEIGHT_BITS-1:0] val);
        logic signed [WEIGHT_BITS-1:0] peak;
        if (row >= MAX_MOTIF_LEN) return;
        weight_mem[row*4 + col] = val;
        peak = weight_mem[row*4];
        for (int c = 1; c < 4; c++) begin
            if (weight_mem[row*4 + c] > peak) peak = weight_mem[row*4 + c];
        end
        row_peak[row] = peak;
    endtask

    // sum of (weight - row peak) over the window; returns 0 (no score) when a base is not acgt
    function automatic bit strand_score(input int len, input bit rev,
                                        output logic signed [SCORE_W-1:0] result);
        longint total;
        int     code;
        int     row;
        int     col;
        total = 0;
        for (int i = 0; i < len; i++) begin
            code = window[MAX_MOTIF_LEN - len + i];
            if (code > BASE_T) return 1'b0;
            row = rev ? len - 1 - i : i;
            col = rev ? BASE_T - code : code;
            total += longint'(weight_mem[row*4 + col]) - longint'(row_peak[row]);
        end
        if (total < longint'(SCORE_MIN)) total = SCORE_MIN;
        result = SCORE_W'(total);
        return 1'b1;
    endfunction

    task automatic scan_base(input logic nr, input logic [7:0] ch,
                             input logic [POS_W-1:0] pos);
        int                        len;
        logic signed [SCORE_W-1:0] sc;
        logic [POS_W-1:0]          first_pos;
        t_hit                      one_hit;
        t_hit                      step_hits[$];
        if (nr) begin
            for (int i = 0; i < MAX_MOTIF_LEN; i++) window[i] = BASE_NONE;
            fill = 0;
        end
        for (int i = 0; i < MAX_MOTIF_LEN - 1; i++) window[i] = window[i+1];
        window[MAX_MOTIF_LEN-1] = code_of(ch);
        if (fill < MAX_MOTIF_LEN) fill++;
        len = (cfg_len == 0) ? 1 : (cfg_len > MAX_MOTIF_LEN) ? MAX_MOTIF_LEN : int'(cfg_len);
        if (fill < len) return;
        first_pos = pos - POS_W'(len - 1);
        if (cfg_mode != MODE_REVERSE && strand_score(len, 1'b0, sc) && sc >= cfg_min) begin
            one_hit = '{sc, first_pos, STRAND_FWD, 1'b0};
            step_hits.insert(step_hits.size(), one_hit);
        end
        if (cfg_mode != MODE_FORWARD && strand_score(len, 1'b1, sc) && sc >= cfg_min) begin
            one_hit = '{sc, first_pos, STRAND_REV, 1'b0};
            step_hits.insert(step_hits.size(), one_hit);
        end
        if (step_hits.size() > 0) step_hits[step_hits.size()-1].last_hit = 1'b1;
        foreach (step_hits[k]) expected_hits.insert(expected_hits.size(), step_hits[k]);
    endtask

    task automatic flag_hit(input bit had_want, input t_hit want, input t_hit got);
        hit_errors++;
        if (hit_errors <= 10) begin
            if (had_want)
                $display("%0t: hit mismatch, expected score %0d start %0d strand %0d last %0d,",
                         $time, want.score, want.start_pos, want.strand, want.last_hit,
                         " got score %0d start %0d strand %0d last %0d",
                         got.score, got.start_pos, got.strand, got.last_hit);
            else
                $display("%0t: unexpected hit, score %0d start %0d strand %0d last %0d",
                         $time, got.score, got.start_pos, got.strand, got.last_hit);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_hit got;
        t_hit want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_MOTIF_LEN; i++) window[i] = BASE_NONE;
            fill     = 0;
            cfg_len  = MOTIF_LEN_W'(1);
            cfg_min  = SCORE_MIN;
            cfg_mode = MODE_BOTH;
            expected_hits.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MOTIF_LENGTH: cfg_len  = i_cfg_data[MOTIF_LEN_W-1:0];
                    REG_MIN_SCORE:    cfg_min  = i_cfg_data;
                    REG_STRAND_MODE:  cfg_mode = i_cfg_data[STRAND_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_kind == KIND_LOAD)
                    load_weight(i_weight_row, i_weight_column, i_weight_value);
                else
                    scan_base(i_new_region, i_base_char, i_position);
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_score, i_start_position, i_strand, i_last_hit};
                if (expected_hits.size() == 0) begin
                    flag_hit(1'b0, got, got);
                end else begin
                    want = expected_hits.pop_front();
                    if (got !== want) flag_hit(1'b1, want, got);
                end
            end
        end
        o_fail_count <= hit_errors;
        o_pending    <= expected_hits.size();
    end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives the pwm motif scanner with matrix loads, directed base runs and
// random motif-shaped streams under several register settings; a checker
// beside the block predicts and compares every hit item
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import pms_pkg::*;

    // spare register index and the odd strand mode, both outside the normal set
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;
    localparam logic [STRAND_W-1:0]  MODE_SPARE = 2'd3;

    localparam int  DRAIN_CYCLES = MAX_MOTIF_LEN + 16;  // longest base item plus margin
    localparam int  PHASE_ITEMS  = 45;
    localparam int  RANDOM_PHASES = 9;
    localparam real LIMIT_NS     = 5_000_000.0;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic                            i_kind;
    logic                            i_new_region;
    logic [7:0]                      i_base_char;
    logic [POS_W-1:0]                i_position;
    logic [WROW_W-1:0]               i_weight_row;
    logic [1:0]                      i_weight_column;
    logic signed [WEIGHT_BITS-1:0]   i_weight_value;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic signed [SCORE_W-1:0]       o_score;
    logic [POS_W-1:0]                o_start_position;
    logic                            o_strand;
    logic                            o_last_hit;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [CFG_IDX_W-1:0]            i_cfg_index;
    logic [SCORE_W-1:0]              i_cfg_data;

    int fail_count;
    int pending_hits;

    // stimulus state: items sent, next base coordinate, idling switch
    int                            items_sent = 0;
    logic [POS_W-1:0]              next_pos = '0;
    bit                            calm = 1'b0;
    int                            stall_left = 0;
    // copy of the loaded weights, only used to steer bases toward the consensus
    logic signed [WEIGHT_BITS-1:0] shadow_w [MAX_MOTIF_LEN][4];

    pwm_motif_scanner_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_new_region     (i_new_region),
        .i_base_char      (i_base_char),
        .i_position       (i_position),
        .i_weight_row     (i_weight_row),
        .i_weight_column  (i_weight_column),
        .i_weight_value   (i_weight_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_score          (o_score),
        .o_start_position (o_start_position),
        .o_strand         (o_strand),
        .o_last_hit       (o_last_hit),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    pms_hit_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_new_region     (i_new_region),
        .i_base_char      (i_base_char),
        .i_position       (i_position),
        .i_weight_row     (i_weight_row),
        .i_weight_column  (i_weight_column),
        .i_weight_value   (i_weight_value),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_score          (o_score),
        .i_start_position (o_start_position),
        .i_strand         (o_strand),
        .i_last_hit       (o_last_hit),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending_hits)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial begin
        #(LIMIT_NS);
        $display("testbench: FAIL");
        $finish;
    end

    // hit side back-pressure: random stall bursts, none when calm
    always @(posedge i_clk) begin
        if (calm) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 6);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // one item on the input channel; valid stays up unless a gap follows
    task automatic send_item(input logic kind, input logic nr, input logic [7:0] ch,
                             input logic [POS_W-1:0] pos, input logic [WROW_W-1:0] row,
                             input logic [1:0] col, input logic signed [WEIGHT_BITS-1:0] val);
        i_in_valid      <= 1'b1;
        i_kind          <= kind;
        i_new_region    <= nr;
        i_base_char     <= ch;
        i_position      <= pos;
        i_weight_row    <= row;
        i_weight_column <= col;
        i_weight_value  <= val;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // weight load, unused base fields carry noise
    task automatic send_load(input logic [WROW_W-1:0] row, input logic [1:0] col,
                             input logic signed [WEIGHT_BITS-1:0] val, input logic nr);
        shadow_w[row][col] = val;
        send_item(KIND_LOAD, nr, 8'($urandom), POS_W'($urandom), row, col, val);
    endtask

    // base at the running coordinate, load fields carry noise
    task automatic send_base(input logic nr, input logic [7:0] ch);
        send_item(KIND_BASE, nr, ch, next_pos, WROW_W'($urandom), 2'($urandom),
                  WEIGHT_BITS'($urandom));
        next_pos = next_pos + 1'b1;
    endtask

    function automatic logic [7:0] base_char_of(input logic [2:0] code, input bit lower);
        case (code)
            BASE_A:  return lower ? CH_A_LO : CH_A_UP;
            BASE_C:  return lower ? CH_C_LO : CH_C_UP;
            BASE_G:  return lower ? CH_G_LO : CH_G_UP;
            default: return lower ? CH_T_LO : CH_T_UP;
        endcase
    endfunction

    function automatic logic [2:0] best_col(input int row);
        logic [2:0] best;
        best = BASE_A;
        for (int c = 1; c < 4; c++) begin
            if (shadow_w[row][c] > shadow_w[row][best]) best = 3'(c);
        end
        return best;
    endfunction

    // new region, coordinates often next to zero or the top of the range
    task automatic start_region();
        case ($urandom_range(0, 2))
            0:       next_pos = POS_W'($urandom_range(0, 40));
            1:       next_pos = {POS_W{1'b1}} - POS_W'($urandom_range(0, 40));
            default: next_pos = POS_W'($urandom);
        endcase
        send_base(1'b1, base_char_of(3'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
    endtask

    // one motif instance on either strand, with the odd mutation or bad base
    task automatic send_motif(input int len, input bit rev);
        logic [2:0] code;
        logic [7:0] ch;
        for (int i = 0; i < len; i++) begin
            code = rev ? BASE_T - best_col(len - 1 - i) : best_col(i);
            if ($urandom_range(0, 11) == 0) code = 3'($urandom_range(0, 3));
            ch = base_char_of(code, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 39) == 0) ch = 8'($urandom);
            send_base(1'b0, ch);
        end
    endtask

    // stop sending and wait until every predicted hit item has been taken
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_hits != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCORE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [MOTIF_LEN_W-1:0] len_reg;
        logic [SCORE_W-1:0]     min_reg;
        logic [STRAND_W-1:0]    mode_reg;
        int                     eff_len;
        int                     phase_end;
        int                     pick;

        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_kind          <= KIND_LOAD;
        i_new_region    <= 1'b0;
        i_base_char     <= '0;
        i_position      <= '0;
        i_weight_row    <= '0;
        i_weight_column <= '0;
        i_weight_value  <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= REG_MOTIF_LENGTH;
        i_cfg_data      <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // whole matrix first, so no scan ever reads an unwritten weight
        for (int r = 0; r < MAX_MOTIF_LEN; r++) begin
            for (int c = 0; c < 4; c++) begin
                send_load(WROW_W'(r), 2'(c), WEIGHT_BITS'($urandom), 1'($urandom));
            end
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        // directed run: 4-base window, every score reported, both strands
        write_reg(REG_MOTIF_LENGTH, SCORE_W'(4));
        write_reg(REG_MIN_SCORE, SCORE_MIN);
        write_reg(REG_STRAND_MODE, SCORE_W'(MODE_BOTH));
        // weight extremes; a load ignores new_region
        send_load(WROW_W'(0), 2'(BASE_A), 16'sh7FFF, 1'b1);
        send_load(WROW_W'(31), 2'(BASE_T), 16'sh8000, 1'b0);
        send_load(WROW_W'(3), 2'(BASE_G), 16'sh0000, 1'b0);
        // filling window, first hits start at coordinate zero
        next_pos = '0;
        send_base(1'b1, CH_A_UP);
        send_base(1'b0, CH_C_LO);
        send_base(1'b0, CH_G_UP);
        send_base(1'b0, CH_T_LO);
        // invalid bases block hits until they leave the window
        send_base(1'b0, 8'h4E);
        send_base(1'b0, 8'h00);
        send_base(1'b0, 8'hFF);
        send_base(1'b0, CH_A_LO);
        // a load in mid-region must not disturb the window
        send_load(WROW_W'(1), 2'(BASE_C), 16'sh1234, 1'b1);
        send_base(1'b0, CH_C_UP);
        send_base(1'b0, CH_G_LO);
        send_base(1'b0, CH_T_UP);
        // coordinates wrap through the top of the range
        next_pos = {POS_W{1'b1}} - POS_W'(2);
        send_base(1'b1, CH_G_LO);
        send_base(1'b0, CH_T_UP);
        send_base(1'b0, CH_A_UP);
        send_base(1'b0, CH_C_LO);
        send_base(1'b0, CH_G_UP);

        // random phases, one register setting each, extremes and odd values included
        for (int p = 1; p <= RANDOM_PHASES; p++) begin
            wait_drained();
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            case (p)
                1: begin len_reg = 6'd1;  mode_reg = MODE_FORWARD; end
                2: begin len_reg = 6'd32; mode_reg = MODE_BOTH;    end
                3: begin len_reg = 6'd0;  mode_reg = MODE_REVERSE; end
                4: begin len_reg = 6'd63; mode_reg = MODE_SPARE;   end
                5: begin len_reg = 6'd6;  mode_reg = MODE_BOTH;    end
                6: begin len_reg = 6'd33; mode_reg = MODE_BOTH;    end
                7: begin len_reg = 6'($urandom_range(1, 8));  mode_reg = MODE_BOTH; end
                8: begin
                    len_reg  = 6'($urandom_range(2, 12));
                    mode_reg = STRAND_W'($urandom_range(0, 3));
                end
                default: begin len_reg = 6'd5; mode_reg = MODE_BOTH; end
            endcase
            eff_len = (len_reg == 0) ? 1 : (len_reg > MAX_MOTIF_LEN) ? MAX_MOTIF_LEN
                                                                     : int'(len_reg);
            // threshold: everything, perfect matches only, nothing, random, or a few mismatches
            case (p)
                1, 4:    min_reg = SCORE_MIN;
                3:       min_reg = '0;
                6:       min_reg = SCORE_W'(5);
                8:       min_reg = SCORE_W'($urandom);
                default: min_reg = SCORE_W'(-int'($urandom_range(0, eff_len * 30000)));
            endcase
            write_reg(REG_MOTIF_LENGTH, SCORE_W'(len_reg));
            write_reg(REG_MIN_SCORE, min_reg);
            write_reg(REG_STRAND_MODE, SCORE_W'(mode_reg));
            if (p == 4) write_reg(REG_SPARE, SCORE_W'($urandom));

            // last phase runs without idling on either side
            calm = (p == RANDOM_PHASES) || ($urandom_range(0, 3) == 0);
            phase_end = items_sent + PHASE_ITEMS;
            start_region();
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    send_load(WROW_W'($urandom), 2'($urandom), WEIGHT_BITS'($urandom),
                              1'($urandom));
                else if (pick < 12)
                    start_region();
                else if (pick < 62)
                    send_motif(eff_len, 1'($urandom_range(0, 1)));
                else if (pick < 67)
                    send_base(1'b0, 8'($urandom));
                else
                    send_base(1'b0, base_char_of(3'($urandom_range(0, 3)),
                                                 1'($urandom_range(0, 1))));
                // now and then hold off until every hit has come out
                if ($urandom_range(0, 59) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_hits == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
